// ===== hw/rtl/rmq_pkg.sv =====
// rmq_pkg: widths, payload types and saturation helper for the rotation
// matrix to quaternion block. No dependencies.
package rmq_pkg;

	localparam int DATA_WIDTH  = 16;
	localparam int FRAC_BITS   = 14;
	localparam int QUEUE_DEPTH = 4;

	// radicand magnitude, up to 3 * 2^(W-1) + 1.0
	localparam int RAD_W  = DATA_WIDTH + 2;
	localparam int SQ_IN_W = RAD_W + FRAC_BITS;
	localparam int SQ_W   = (SQ_IN_W + 1) / 2;
	localparam int SQ_PAD = 2 * SQ_W;
	// off-diagonal sum or difference
	localparam int NUM_W  = DATA_WIDTH + 1;
	localparam int DIV_W  = NUM_W + FRAC_BITS;

	typedef enum logic [1:0] {
		AX_X = 2'd0,
		AX_Y = 2'd1,
		AX_Z = 2'd2,
		AX_W = 2'd3
	} axis_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] row1_col1;
		logic signed [DATA_WIDTH-1:0] row1_col2;
		logic signed [DATA_WIDTH-1:0] row1_col3;
		logic signed [DATA_WIDTH-1:0] row2_col1;
		logic signed [DATA_WIDTH-1:0] row2_col2;
		logic signed [DATA_WIDTH-1:0] row2_col3;
		logic signed [DATA_WIDTH-1:0] row3_col1;
		logic signed [DATA_WIDTH-1:0] row3_col2;
		logic signed [DATA_WIDTH-1:0] row3_col3;
	} mat_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] quat_x;
		logic signed [DATA_WIDTH-1:0] quat_y;
		logic signed [DATA_WIDTH-1:0] quat_z;
		logic signed [DATA_WIDTH-1:0] quat_w;
	} quat_t;

	// classified job handed from front to back
	typedef struct packed {
		axis_t                     axis;
		logic [RAD_W-1:0]          rad;
		logic [2:0][NUM_W-1:0]     num;
	} job_t;

	function automatic logic signed [DATA_WIDTH-1:0] sat(input logic signed [DIV_W:0] v);
		logic signed [DIV_W:0] hi;
		logic signed [DIV_W:0] lo;
		hi = (DIV_W+1)'((64'sd1 <<< (DATA_WIDTH-1)) - 64'sd1);
		lo = -hi - (DIV_W+1)'(1);
		if (v > hi) begin
			return hi[DATA_WIDTH-1:0];
		end else if (v < lo) begin
			return lo[DATA_WIDTH-1:0];
		end
		return v[DATA_WIDTH-1:0];
	endfunction

endpackage

// ===== hw/rtl/rmq_front.sv =====
// rmq_front: trace test, axis pick, radicand and off-diagonal numerators.
// Depends on rmq_pkg.
module rmq_front (
	input  rmq_pkg::mat_t m,
	output rmq_pkg::job_t job
);
	import rmq_pkg::*;

	localparam int TR_W = DATA_WIDTH + 3;

	logic signed [TR_W-1:0] e11, e22, e33, tr, rad, one;
	logic signed [NUM_W-1:0] n_xw, n_yw, n_zw, n_xy, n_xz, n_yz;

	always_comb begin
		e11 = TR_W'(m.row1_col1);
		e22 = TR_W'(m.row2_col2);
		e33 = TR_W'(m.row3_col3);
		one = TR_W'(64'sd1 <<< FRAC_BITS);
		tr  = e11 + e22 + e33;
		n_xw = NUM_W'(m.row2_col3) - NUM_W'(m.row3_col2);
		n_yw = NUM_W'(m.row3_col1) - NUM_W'(m.row1_col3);
		n_zw = NUM_W'(m.row1_col2) - NUM_W'(m.row2_col1);
		n_xy = NUM_W'(m.row2_col1) + NUM_W'(m.row1_col2);
		n_xz = NUM_W'(m.row3_col1) + NUM_W'(m.row1_col3);
		n_yz = NUM_W'(m.row3_col2) + NUM_W'(m.row2_col3);
		if (tr > 0) begin
			job.axis = AX_W;
			rad      = tr + one;
			job.num  = {n_zw, n_yw, n_xw};
		end else if (m.row1_col1 >= m.row2_col2 && m.row1_col1 >= m.row3_col3) begin
			job.axis = AX_X;
			rad      = e11 - e22 - e33 + one;
			job.num  = {n_xw, n_xz, n_xy};
		end else if (m.row2_col2 > m.row3_col3) begin
			job.axis = AX_Y;
			rad      = e22 - e11 - e33 + one;
			job.num  = {n_yw, n_yz, n_xy};
		end else begin
			job.axis = AX_Z;
			rad      = e33 - e11 - e22 + one;
			job.num  = {n_zw, n_yz, n_xz};
		end
		if (rad < one) begin
			rad = one;
		end
		job.rad = rad[RAD_W-1:0];
	end

endmodule

// ===== hw/rtl/rmq_queue.sv =====
// rmq_queue: small register FIFO of classified jobs between front and back.
// Depends on rmq_pkg.
module rmq_queue #(
	parameter int DEPTH = rmq_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rmq_pkg::job_t wdata,
	output logic          full,
	input  logic          pop,
	output logic          avail,
	output rmq_pkg::job_t rdata
);
	import rmq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign avail = (cnt_q != '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

endmodule

// ===== hw/rtl/rmq_back.sv =====
// rmq_back: pipelined square root (one root bit per stage), three
// pipelined restoring dividers (one quotient bit per stage), saturation
// and output register. Depends on rmq_pkg.
module rmq_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  rmq_pkg::job_t head,
	output logic          pop,
	output logic          quat_valid,
	input  logic          quat_stall,
	output rmq_pkg::quat_t quat
);
	import rmq_pkg::*;

	logic adv;
	assign adv = !quat_valid || !quat_stall;
	assign pop = adv && head_valid;

	// square root stages
	logic                  sq_v    [SQ_W+1];
	logic [SQ_PAD-1:0]     sq_rad  [SQ_W+1];
	logic [SQ_W+1:0]       sq_rem  [SQ_W+1];
	logic [SQ_W-1:0]       sq_root [SQ_W+1];
	axis_t                 sq_axis [SQ_W+1];
	logic [2:0][NUM_W-1:0] sq_num  [SQ_W+1];

	assign sq_v[0]    = head_valid;
	assign sq_rad[0]  = SQ_PAD'({head.rad, {FRAC_BITS{1'b0}}});
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_axis[0] = head.axis;
	assign sq_num[0]  = head.num;

	for (genvar k = 0; k < SQ_W; k++) begin : g_sq
		logic [SQ_W+3:0] cat, trial;
		logic [SQ_W+1:0] rem_n;
		logic [SQ_W-1:0] root_n;
		always_comb begin
			cat   = {sq_rem[k], sq_rad[k][SQ_PAD-1 -: 2]};
			trial = (SQ_W+4)'({sq_root[k], 2'b01});
			if (cat >= trial) begin
				rem_n  = SQ_W'(0) + (SQ_W+2)'(cat - trial);
				root_n = {sq_root[k][SQ_W-2:0], 1'b1};
			end else begin
				rem_n  = cat[SQ_W+1:0];
				root_n = {sq_root[k][SQ_W-2:0], 1'b0};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[k+1] <= 1'b0;
			end else if (adv) begin
				sq_v[k+1] <= sq_v[k];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_rad[k+1]  <= sq_rad[k] << 2;
				sq_rem[k+1]  <= rem_n;
				sq_root[k+1] <= root_n;
				sq_axis[k+1] <= sq_axis[k];
				sq_num[k+1]  <= sq_num[k];
			end
		end
	end

	// divider stages, three lanes sharing one divisor t = 2 * root
	logic                  dv_v    [DIV_W+1];
	logic [SQ_W:0]         dv_t    [DIV_W+1];
	logic [SQ_W-2:0]       dv_qtr  [DIV_W+1];
	axis_t                 dv_axis [DIV_W+1];
	logic [2:0]            dv_neg  [DIV_W+1];
	logic [2:0][SQ_W:0]    dv_rem  [DIV_W+1];
	logic [2:0][DIV_W-1:0] dv_dvd  [DIV_W+1];

	always_comb begin
		logic [NUM_W-1:0] n;
		dv_v[0]    = sq_v[SQ_W];
		dv_t[0]    = {sq_root[SQ_W], 1'b0};
		dv_qtr[0]  = sq_root[SQ_W][SQ_W-1:1];
		dv_axis[0] = sq_axis[SQ_W];
		dv_rem[0]  = '0;
		for (int j = 0; j < 3; j++) begin
			n = sq_num[SQ_W][j];
			dv_neg[0][j] = n[NUM_W-1];
			dv_dvd[0][j] = {(n[NUM_W-1] ? -n : n), {FRAC_BITS{1'b0}}};
		end
	end

	for (genvar k = 0; k < DIV_W; k++) begin : g_dv
		logic [2:0][SQ_W:0]    rem_n;
		logic [2:0][DIV_W-1:0] dvd_n;
		always_comb begin
			logic [SQ_W+1:0] cat;
			logic            ge;
			for (int j = 0; j < 3; j++) begin
				cat = {dv_rem[k][j], dv_dvd[k][j][DIV_W-1]};
				ge  = (cat >= (SQ_W+2)'(dv_t[k]));
				rem_n[j] = ge ? (SQ_W+1)'(cat - (SQ_W+2)'(dv_t[k])) : cat[SQ_W:0];
				dvd_n[j] = {dv_dvd[k][j][DIV_W-2:0], ge};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[k+1] <= 1'b0;
			end else if (adv) begin
				dv_v[k+1] <= dv_v[k];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_t[k+1]    <= dv_t[k];
				dv_qtr[k+1]  <= dv_qtr[k];
				dv_axis[k+1] <= dv_axis[k];
				dv_neg[k+1]  <= dv_neg[k];
				dv_rem[k+1]  <= rem_n;
				dv_dvd[k+1]  <= dvd_n;
			end
		end
	end

	// sign, saturate and place by axis
	logic signed [DATA_WIDTH-1:0] r0, r1, r2, rq;
	quat_t                        res;

	always_comb begin
		logic signed [DIV_W:0] q [3];
		for (int j = 0; j < 3; j++) begin
			q[j] = $signed({1'b0, dv_dvd[DIV_W][j]});
			if (dv_neg[DIV_W][j]) begin
				q[j] = -q[j];
			end
		end
		r0 = sat(q[0]);
		r1 = sat(q[1]);
		r2 = sat(q[2]);
		rq = sat($signed((DIV_W+1)'(dv_qtr[DIV_W])));
		unique case (dv_axis[DIV_W])
			AX_X:    res = '{quat_x: rq, quat_y: r0, quat_z: r1, quat_w: r2};
			AX_Y:    res = '{quat_x: r0, quat_y: rq, quat_z: r1, quat_w: r2};
			AX_Z:    res = '{quat_x: r0, quat_y: r1, quat_z: rq, quat_w: r2};
			default: res = '{quat_x: r0, quat_y: r1, quat_z: r2, quat_w: rq};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_valid <= 1'b0;
		end else if (adv) begin
			quat_valid <= dv_v[DIV_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			quat <= res;
		end
	end

endmodule

// ===== hw/rtl/rotation_matrix_to_quaternion.sv =====
// rotation_matrix_to_quaternion: top level, front classifier, job queue
// and back pipeline. Depends on rmq_pkg, rmq_front, rmq_queue, rmq_back.
//
//   channel | valid      | stall      | word            | dir
//   matrix  | mat_valid  | mat_stall  | mat  (mat_t)    | in
//   quat    | quat_valid | quat_stall | quat (quat_t)   | out
//
// One word accepted per cycle while mat_stall is low. Words are Q1.14 in
// 16 bits. Each job passes the square root stages (one root bit each),
// then the restoring divider stages (one quotient bit each), then the
// output register. The queue write happens on the accepting edge itself.
// arst_n clears the queue pointers and all stage valid bits; payload
// registers are not reset. A stall on quat while quat_valid is high
// freezes the whole back pipeline; the front keeps filling the queue and
// raises mat_stall only once the queue is full.
module rotation_matrix_to_quaternion #(
	parameter int QUEUE_DEPTH = rmq_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           mat_valid,
	output logic           mat_stall,
	input  rmq_pkg::mat_t  mat,
	output logic           quat_valid,
	input  logic           quat_stall,
	output rmq_pkg::quat_t quat
);
	import rmq_pkg::*;

	job_t job_in, job_head;
	logic full, avail, pop;

	// trace test and axis pick happen before the queue
	rmq_front u_front (
		.m   (mat),
		.job (job_in)
	);

	assign mat_stall = full;

	rmq_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mat_valid && !full),
		.wdata  (job_in),
		.full   (full),
		.pop    (pop),
		.avail  (avail),
		.rdata  (job_head)
	);

	// sqrt, divide, saturate; output register parts it from the sink
	rmq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (avail),
		.head       (job_head),
		.pop        (pop),
		.quat_valid (quat_valid),
		.quat_stall (quat_stall),
		.quat       (quat)
	);

endmodule

// ===== hw/rtl/rmq_checker.sv =====
// rmq_checker: port-level assertions for the top level, bound in below.
// Depends on rmq_pkg and rotation_matrix_to_quaternion.
module rmq_checker #(
	parameter int QUEUE_DEPTH = rmq_pkg::QUEUE_DEPTH
) (
	input logic           clk,
	input logic           arst_n,
	input logic           mat_valid,
	input logic           mat_stall,
	input logic           quat_valid,
	input logic           quat_stall,
	input rmq_pkg::quat_t quat
);
	import rmq_pkg::*;

	localparam int CAP = QUEUE_DEPTH + SQ_W + DIV_W + 1;

	logic [15:0] pend_q;
	logic        in_acc, out_acc;

	assign in_acc  = mat_valid && !mat_stall;
	assign out_acc = quat_valid && !quat_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 16'(in_acc) - 16'(out_acc);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid && quat_stall |=> quat_valid)
		else $error("quat word dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid && quat_stall |=> $stable(quat))
		else $error("quat word changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid |-> pend_q != '0)
		else $error("quat word without a pending matrix");

	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 16'(CAP))
		else $error("more words in flight than the pipeline holds");

endmodule

bind rotation_matrix_to_quaternion rmq_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_rmq_checker (.*);

// ===== verif/testbench.sv =====
// testbench: self-checking bench for rotation_matrix_to_quaternion.
// Needs rmq_pkg and the block's RTL; drives matrices, checks quaternions
// against an in-bench fixed point model.
`timescale 1ns / 100ps

module testbench;
	import rmq_pkg::*;

	localparam int N_RANDOM  = 830;
	localparam int DRAIN_CYC = 80;
	localparam int HOLD_CYC  = 300;  // long receiver hold-off

	typedef struct {
		mat_t  m;
		bit    known;   // expected word typed in below
		quat_t q;
	} row_t;

	logic  clk;
	logic  arst_n;
	logic  mat_valid;
	logic  mat_stall;
	mat_t  mat;
	logic  quat_valid;
	logic  quat_stall;
	quat_t quat;

	quat_t pending_quats[$];  // predicted words, oldest first
	int    n_errors;
	int    n_sent;
	bit    hold_started;

	rotation_matrix_to_quaternion u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.mat_valid  (mat_valid),
		.mat_stall  (mat_stall),
		.mat        (mat),
		.quat_valid (quat_valid),
		.quat_stall (quat_stall),
		.quat       (quat)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// ---------------------------------------------------------------
	// fixed point model
	// ---------------------------------------------------------------
	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic signed [DATA_WIDTH-1:0] clamp16(longint v);
		longint hi;
		hi = (longint'(1) <<< (DATA_WIDTH-1)) - 1;
		if (v > hi)
			v = hi;
		if (v < -hi - 1)
			v = -hi - 1;
		return v[DATA_WIDTH-1:0];
	endfunction

	// signed longint division truncates toward zero; t is always >= 2.0
	function automatic longint over_t(longint num, longint t);
		return (num <<< FRAC_BITS) / t;
	endfunction

	function automatic quat_t matrix_to_quat(mat_t m);
		longint a11, a12, a13, a21, a22, a23, a31, a32, a33;
		longint one, tr, rad, t, qtr, x, y, z, w;
		axis_t  ax;
		quat_t  q;
		a11 = m.row1_col1; a12 = m.row1_col2; a13 = m.row1_col3;
		a21 = m.row2_col1; a22 = m.row2_col2; a23 = m.row2_col3;
		a31 = m.row3_col1; a32 = m.row3_col2; a33 = m.row3_col3;
		one = longint'(1) <<< FRAC_BITS;
		tr  = a11 + a22 + a33;
		// trace zero falls through to the diagonal branches
		if (tr > 0) begin
			rad = tr + one;
			ax  = AX_W;
		end else if (a11 >= a22 && a11 >= a33) begin
			rad = a11 - a22 - a33 + one;
			ax  = AX_X;
		end else if (a22 > a33) begin
			rad = a22 - a11 - a33 + one;
			ax  = AX_Y;
		end else begin
			rad = a33 - a11 - a22 + one;
			ax  = AX_Z;
		end
		if (rad < one)
			rad = one;
		t   = 2 * longint'(floor_root(longint'(rad) <<< FRAC_BITS));
		qtr = t >>> 2;
		case (ax)
			AX_W: begin
				x = over_t(a23 - a32, t); y = over_t(a31 - a13, t);
				z = over_t(a12 - a21, t); w = qtr;
			end
			AX_X: begin
				x = qtr;                  y = over_t(a21 + a12, t);
				z = over_t(a31 + a13, t); w = over_t(a23 - a32, t);
			end
			AX_Y: begin
				x = over_t(a21 + a12, t); y = qtr;
				z = over_t(a32 + a23, t); w = over_t(a31 - a13, t);
			end
			default: begin
				x = over_t(a31 + a13, t); y = over_t(a32 + a23, t);
				z = qtr;                  w = over_t(a12 - a21, t);
			end
		endcase
		q.quat_x = clamp16(x);
		q.quat_y = clamp16(y);
		q.quat_z = clamp16(z);
		q.quat_w = clamp16(w);
		return q;
	endfunction

	function automatic mat_t build_mat(int e11, int e12, int e13, int e21, int e22,
			int e23, int e31, int e32, int e33);
		mat_t m;
		m.row1_col1 = e11[15:0]; m.row1_col2 = e12[15:0]; m.row1_col3 = e13[15:0];
		m.row2_col1 = e21[15:0]; m.row2_col2 = e22[15:0]; m.row2_col3 = e23[15:0];
		m.row3_col1 = e31[15:0]; m.row3_col2 = e32[15:0]; m.row3_col3 = e33[15:0];
		return m;
	endfunction

	function automatic int rnd_elem(int lim);
		return $signed($urandom_range(0, 2 * lim)) - lim;
	endfunction

	// random matrix: raw bits, elements within +-1.0, or one axis dominant
	function automatic mat_t random_mat();
		mat_t         m;
		logic [159:0] raw;
		int           kind;
		int           ax;
		kind = $urandom_range(0, 9);
		if (kind < 4) begin
			raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
			m   = raw[$bits(mat_t)-1:0];
		end else if (kind < 8) begin
			m = build_mat(rnd_elem(16384), rnd_elem(16384), rnd_elem(16384),
				rnd_elem(16384), rnd_elem(16384), rnd_elem(16384),
				rnd_elem(16384), rnd_elem(16384), rnd_elem(16384));
		end else begin
			// mostly negative trace with one diagonal element on top
			m = build_mat(-rnd_elem(4000) - 12000, rnd_elem(16384), rnd_elem(16384),
				rnd_elem(16384), -rnd_elem(4000) - 12000, rnd_elem(16384),
				rnd_elem(16384), rnd_elem(16384), -rnd_elem(4000) - 12000);
			ax = $urandom_range(0, 2);
			case (ax)
				0: m.row1_col1 = 16'($urandom_range(0, 16384));
				1: m.row2_col2 = 16'($urandom_range(0, 16384));
				default: m.row3_col3 = 16'($urandom_range(0, 16384));
			endcase
		end
		return m;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// ---------------------------------------------------------------
	// matrix side
	// ---------------------------------------------------------------
	task automatic send_matrix(mat_t m, bit no_gap);
		int g;
		g = no_gap ? 0 : pick_gap();
		@(negedge clk);
		if (g > 0) begin
			mat_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		mat_valid <= 1'b1;
		mat       <= m;
		// accepted at the first edge with stall low
		do
			@(posedge clk);
		while (mat_stall);
		pending_quats.push_back(matrix_to_quat(m));
		n_sent++;
	endtask

	// ---------------------------------------------------------------
	// quaternion side: random stall, quiet stretches, one long hold-off
	// ---------------------------------------------------------------
	int stall_left;
	int quiet_left;

	always @(negedge clk) begin
		if (!arst_n) begin
			quat_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			quat_stall <= 1'b1;
		end else if (!hold_started && n_sent >= 400) begin
			// sender keeps pushing so the queue fills and mat_stall rises
			hold_started = 1'b1;
			stall_left   = HOLD_CYC;
			quat_stall <= 1'b1;
		end else if (quiet_left > 0) begin
			quiet_left--;
			quat_stall <= 1'b0;
		end else if ($urandom_range(0, 99) < 3) begin
			quiet_left = $urandom_range(50, 200);
			quat_stall <= 1'b0;
		end else begin
			stall_left = pick_gap();
			quat_stall <= (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// compare each accepted word with the oldest prediction
	always @(posedge clk) begin
		quat_t want;
		if (arst_n && quat_valid && !quat_stall) begin
			if (pending_quats.size() == 0) begin
				$error("unexpected quaternion word %h", quat);
				n_errors++;
			end else begin
				want = pending_quats.pop_front();
				if (quat.quat_x !== want.quat_x) begin
					$error("quat_x exp %0d got %0d", want.quat_x, quat.quat_x);
					n_errors++;
				end
				if (quat.quat_y !== want.quat_y) begin
					$error("quat_y exp %0d got %0d", want.quat_y, quat.quat_y);
					n_errors++;
				end
				if (quat.quat_z !== want.quat_z) begin
					$error("quat_z exp %0d got %0d", want.quat_z, quat.quat_z);
					n_errors++;
				end
				if (quat.quat_w !== want.quat_w) begin
					$error("quat_w exp %0d got %0d", want.quat_w, quat.quat_w);
					n_errors++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	initial begin
		row_t rows[$];
		row_t rw;
		int   i;
		arst_n     = 1'b0;
		mat_valid  = 1'b0;
		mat        = '0;
		quat_stall = 1'b0;
		n_errors   = 0;
		n_sent     = 0;
		hold_started = 1'b0;
		stall_left = 0;
		quiet_left = 0;

		// identity: positive trace, t = 4.0, w = 1.0
		rw.m = build_mat(16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
		rw.known = 1'b1; rw.q = '{0, 0, 0, 16384};
		rows.push_back(rw);
		// all zero: trace zero, tie goes to row1_col1, t = 2.0
		rw.m = '0;
		rw.known = 1'b1; rw.q = '{8192, 0, 0, 0};
		rows.push_back(rw);
		rw.known = 1'b0;
		// extremes of every field
		rw.m = {9{16'sh7fff}};  rows.push_back(rw);
		rw.m = {9{16'sh8000}};  rows.push_back(rw);
		rw.m = {9{16'shffff}};  rows.push_back(rw);
		rw.m = build_mat(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768);
		rows.push_back(rw);
		rw.m = build_mat(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767);
		rows.push_back(rw);
		// each diagonal axis, rotations by 180 degrees
		rw.m = build_mat(16384, 0, 0, 0, -16384, 0, 0, 0, -16384); rows.push_back(rw);
		rw.m = build_mat(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384); rows.push_back(rw);
		rw.m = build_mat(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384); rows.push_back(rw);
		// ties: row2_col2 equals row3_col3 goes to the third axis
		rw.m = build_mat(-16384, 300, -200, 100, 0, 50, -70, 900, 0); rows.push_back(rw);
		// row1_col1 ties with another diagonal element
		rw.m = build_mat(-100, 5, 6, 7, -100, 8, 9, 10, -16384); rows.push_back(rw);
		// trace exactly zero
		rw.m = build_mat(16384, 1000, -2000, 3000, -16384, 4000, -5000, 6000, 0);
		rows.push_back(rw);
		// small divisors with huge off-diagonal sums and differences, both signs
		rw.m = build_mat(0, 32767, 32767, 32767, 0, -32768, 32767, 32767, -32768);
		rows.push_back(rw);
		rw.m = build_mat(-32768, -32768, -32768, -32768, 0, -32768, -32768, -32768, 0);
		rows.push_back(rw);
		rw.m = build_mat(1, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0);
		rows.push_back(rw);
		// 90 degree rotations about each axis
		rw.m = build_mat(16384, 0, 0, 0, 0, 16384, 0, -16384, 0); rows.push_back(rw);
		rw.m = build_mat(0, 0, -16384, 0, 16384, 0, 16384, 0, 0); rows.push_back(rw);
		rw.m = build_mat(0, 16384, 0, -16384, 0, 0, 0, 0, 16384); rows.push_back(rw);
		// smallest positive trace
		rw.m = build_mat(1, 77, -77, 500, 0, -500, 32767, -32768, 0); rows.push_back(rw);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows back to back; typed-in values checked against the model
		foreach (rows[k]) begin
			if (rows[k].known && matrix_to_quat(rows[k].m) !== rows[k].q) begin
				$error("model row %0d exp %h got %h", k, rows[k].q,
					matrix_to_quat(rows[k].m));
				n_errors++;
			end
			send_matrix(rows[k].m, 1'b1);
		end

		for (i = 0; i < N_RANDOM; i++)
			send_matrix(random_mat(), (i >= 600 && i < 700));

		@(negedge clk);
		mat_valid <= 1'b0;

		while (pending_quats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		if (n_errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#1_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/rmq_pkg.sv
hw/rtl/rmq_front.sv
hw/rtl/rmq_queue.sv
hw/rtl/rmq_back.sv
hw/rtl/rotation_matrix_to_quaternion.sv
hw/rtl/rmq_checker.sv
verif/testbench.sv
